// File: src/bilinear_grid_interpolation_defines.svh
// assertion macros for the bilinear grid interpolation block
`ifndef BILINEAR_GRID_INTERPOLATION_DEFINES_SVH
`define BILINEAR_GRID_INTERPOLATION_DEFINES_SVH
// assert that a condition implies a consequence in the same cycle
`define BGI_ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define BGI_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

// File: src/bgi_pkg.sv
// package for the bilinear grid interpolation block: types and constants
package bgi_pkg;
    localparam int MAX_COLUMNS_DEF = 64;
    localparam int MAX_ROWS_DEF    = 64;
    localparam int DATA_W          = 32;
    localparam int COUNT_W         = 7;
    localparam int INDEX_W         = 6;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        OP_LOAD_COL  = 2'd0,
        OP_LOAD_ROW  = 2'd1,
        OP_LOAD_GRID = 2'd2,
        OP_QUERY     = 2'd3
    } op_t;

    localparam logic [0:0] CFG_COLUMNS = 1'b0;
    localparam logic [0:0] CFG_ROWS    = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_END_RD,
        ST_END_CHK,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_BRK_RD,
        ST_BRK_LO,
        ST_BRK_HI,
        ST_DIV,
        ST_COR_RD,
        ST_COR_MUL,
        ST_COR_ACC,
        ST_ROUND,
        ST_OUT
    } state_t;
endpackage

// File: src/bgi_ram.sv
// generic single port ram with registered read
module bgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: src/bilinear_grid_interpolation.sv
// top level of the bilinear grid interpolation block
//
//  channel  | signals                                  | dir
//  in       | in_valid, in_stall, op .. query_y          | request in
//  out      | out_valid, out_stall, interpolated_value.. | result out
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data  | register write
//
// loads are written in the cycle they are accepted; a query holds the block until its
// result is taken, run by the sequencer around the multipliers, the restoring divider
// and the single-port rams: four end reads, two bisections of a read and a compare per
// probe, two divides (skipped on trivial weights), four corner reads with two multiplies
// each, a rounding step and the result state (reached at once when out of range).
// reset clears control state and sets the count registers to 64; tables undefined until loaded.
// in_stall is high while a query is under way or its result is on the output.
`include "bilinear_grid_interpolation_defines.svh"
module bilinear_grid_interpolation
    import bgi_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                op,
    input  logic [INDEX_W-1:0]        column_index,
    input  logic [INDEX_W-1:0]        row_index,
    input  logic signed [DATA_W-1:0]  load_value,
    input  logic signed [DATA_W-1:0]  query_x,
    input  logic signed [DATA_W-1:0]  query_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DATA_W-1:0]  interpolated_value,
    output logic                      out_of_range,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [COUNT_W-1:0]        cfg_data
);
    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int MW  = (CW > RW) ? CW : RW;
    localparam int GW  = CW + RW;
    localparam int NW  = MW + 1;

    // state and registers
    state_t state_reg, state_next;
    logic [COUNT_W-1:0] ncol_reg, nrow_reg;
    logic signed [DATA_W-1:0] qx_reg, qy_reg;
    logic axis_reg, axis_next;          // 0 column, 1 row
    logic end_reg, end_next;            // end check: 0 first, 1 last
    logic oor_reg, oor_next;
    logic [MW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] ci_reg, ci_next;
    logic [RW-1:0] rj_reg, rj_next;
    logic signed [DATA_W:0] blo_reg, blo_next;
    logic [DATA_W:0] span_reg, span_next;
    logic [DATA_W+16:0] rem_reg, rem_next;
    logic [16:0] quo_reg, quo_next;
    logic [4:0] step_reg, step_next;
    logic [16:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [1:0] corner_reg, corner_next;
    logic [33:0] w_reg, w_next;
    logic signed [66:0] prod_reg, prod_next;
    logic signed [67:0] sum_reg, sum_next;
    logic signed [DATA_W-1:0] res_reg, res_next;

    // clamped counts
    logic [MW:0] nc, nr, ncur;
    always_comb
    begin
        if (ncol_reg < COUNT_W'(2)) nc = NW'(2);
        else if (32'(ncol_reg) > MAX_COLUMNS) nc = NW'(MAX_COLUMNS);
        else nc = NW'(ncol_reg);
        if (nrow_reg < COUNT_W'(2)) nr = NW'(2);
        else if (32'(nrow_reg) > MAX_ROWS) nr = NW'(MAX_ROWS);
        else nr = NW'(nrow_reg);
        ncur = axis_reg ? nr : nc;
    end

    // breakpoint and grid memories
    logic col_we, row_we, grid_we;
    logic [CW-1:0] col_addr;
    logic [RW-1:0] row_addr;
    logic [GW-1:0] grid_addr;
    logic [DATA_W-1:0] col_rd, row_rd, grid_rd;
    logic in_acc;
    logic [MW-1:0] probe;
    logic [MW:0] mid_w;

    assign in_acc = in_valid && !in_stall;
    assign mid_w  = ({1'b0, lo_reg} + {1'b0, hi_reg} + NW'(1)) >> 1;

    always_comb
    begin
        probe = '0;
        case (state_reg)
            ST_END_RD:  probe = end_reg ? MW'(ncur - NW'(1)) : '0;
            ST_SRCH_RD: probe = mid_w[MW-1:0];
            ST_BRK_RD:  probe = lo_reg;
            ST_BRK_LO:  probe = lo_reg + MW'(1);
            default:    probe = '0;
        endcase
    end

    always_comb
    begin
        col_we  = in_acc && op == OP_LOAD_COL && 32'(column_index) < MAX_COLUMNS;
        row_we  = in_acc && op == OP_LOAD_ROW && 32'(row_index) < MAX_ROWS;
        grid_we = in_acc && op == OP_LOAD_GRID && 32'(column_index) < MAX_COLUMNS
                  && 32'(row_index) < MAX_ROWS;
        col_addr  = col_we ? CW'(column_index) : CW'(probe);
        row_addr  = row_we ? RW'(row_index) : RW'(probe);
        grid_addr = grid_we ? {CW'(column_index), RW'(row_index)}
                            : {ci_reg + CW'(corner_reg[1]), rj_reg + RW'(corner_reg[0])};
    end

    bgi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLUMNS)) u_col_ram (
        .clk(clk), .we(col_we), .addr(col_addr), .wdata(load_value), .rdata(col_rd));
    bgi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_row_ram (
        .clk(clk), .we(row_we), .addr(row_addr), .wdata(load_value), .rdata(row_rd));
    bgi_ram #(.WIDTH(DATA_W), .DEPTH(1 << GW)) u_grid_ram (
        .clk(clk), .we(grid_we), .addr(grid_addr), .wdata(load_value), .rdata(grid_rd));

    logic signed [DATA_W-1:0] bp_rd, qcur;
    assign bp_rd = axis_reg ? $signed(row_rd) : $signed(col_rd);
    assign qcur  = axis_reg ? qy_reg : qx_reg;

    // shared datapath: compare, subtract/divide step, multiply
    logic signed [DATA_W:0] diff;
    logic [3:0] shamt;
    logic [DATA_W+16:0] trial;
    logic [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [66:0] mul_p;
    logic [16:0] wxs, wys;
    logic [16:0] wght;

    assign diff  = (state_reg == ST_BRK_HI) ? ($signed({bp_rd[DATA_W-1], bp_rd}) - blo_reg)
                                            : ($signed({qcur[DATA_W-1], qcur})
                                               - $signed({bp_rd[DATA_W-1], bp_rd}));
    // divide steps 16..1 produce quotient bits 15..0
    assign shamt = step_reg[3:0] - 4'd1;
    assign trial = rem_reg - ({16'd0, span_reg} << shamt);
    assign mul_b = (state_reg == ST_COR_MUL) ? $signed({grid_rd[DATA_W-1], grid_rd})
                                             : 33'sd0;
    assign mul_a = w_reg;
    assign mul_p = $signed({1'b0, mul_a}) * mul_b;
    assign wght  = (quo_reg > ONE_Q16) ? ONE_Q16 : quo_reg;
    assign wxs   = corner_reg[1] ? ax_reg : ONE_Q16 - ax_reg;
    assign wys   = corner_reg[0] ? ay_reg : ONE_Q16 - ay_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_acc && op == OP_QUERY) state_next = ST_END_RD;
            ST_END_RD:   state_next = ST_END_CHK;
            ST_END_CHK:
            begin
                if (end_reg && axis_reg) state_next = oor_next ? ST_OUT : ST_SRCH_RD;
                else state_next = ST_END_RD;
            end
            ST_SRCH_RD:  state_next = (lo_reg == hi_reg) ? ST_BRK_RD : ST_SRCH_CMP;
            ST_SRCH_CMP: state_next = ST_SRCH_RD;
            ST_BRK_RD:   state_next = ST_BRK_LO;
            ST_BRK_LO:   state_next = ST_BRK_HI;
            ST_BRK_HI:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (step_reg == 5'd0) state_next = axis_reg ? ST_COR_RD : ST_SRCH_RD;
            end
            ST_COR_RD:   state_next = ST_COR_MUL;
            ST_COR_MUL:  state_next = ST_COR_ACC;
            ST_COR_ACC:  state_next = (corner_reg == 2'd3) ? ST_ROUND : ST_COR_RD;
            ST_ROUND:    state_next = ST_OUT;
            ST_OUT:      if (!out_stall) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath updates per state
    logic signed [67:0] rsum;
    logic signed [35:0] rtop;
    always_comb
    begin
        axis_next = axis_reg;  end_next = end_reg;  oor_next = oor_reg;
        lo_next = lo_reg;  hi_next = hi_reg;  ci_next = ci_reg;  rj_next = rj_reg;
        blo_next = blo_reg;  span_next = span_reg;  rem_next = rem_reg;
        quo_next = quo_reg;  step_next = step_reg;  ax_next = ax_reg;  ay_next = ay_reg;
        corner_next = corner_reg;  w_next = w_reg;  prod_next = prod_reg;
        sum_next = sum_reg;  res_next = res_reg;
        rsum = sum_reg + 68'sh80000000;
        rtop = rsum[67:32];
        case (state_reg)
            ST_IDLE:
            begin
                axis_next = 1'b0;  end_next = 1'b0;  oor_next = 1'b0;
            end
            ST_END_CHK:
            begin
                if (end_reg ? (diff > 0) : (diff < 0)) oor_next = 1'b1;
                end_next = !end_reg;
                if (end_reg) axis_next = !axis_reg;
                if (end_reg && axis_reg)
                begin
                    axis_next = 1'b0;
                    lo_next = '0;
                    hi_next = MW'(nc - NW'(2));
                end
            end
            ST_SRCH_CMP:
            begin
                if (diff >= 0) lo_next = mid_w[MW-1:0];
                else hi_next = mid_w[MW-1:0] - MW'(1);
            end
            ST_BRK_LO:
            begin
                blo_next = $signed({bp_rd[DATA_W-1], bp_rd});
                rem_next = {16'd0, diff[DATA_W] ? {(DATA_W+1){1'b0}} : diff};
                if (axis_reg) rj_next = RW'(lo_reg);
                else ci_next = CW'(lo_reg);
            end
            ST_BRK_HI:
            begin
                span_next = diff[DATA_W] ? '0 : diff;
                quo_next = '0;
                step_next = 5'd16;
                if (diff <= 0 || rem_reg == '0)
                begin
                    span_next = '0;
                    step_next = 5'd0;
                end
                else if (rem_reg >= {16'd0, diff})
                begin
                    quo_next = ONE_Q16;
                    step_next = 5'd0;
                end
                else
                begin
                    rem_next = rem_reg << 16;
                end
            end
            ST_DIV:
            begin
                // one restoring step per cycle, then the weight is taken
                if (step_reg != 5'd0)
                begin
                    if (!trial[DATA_W+16])
                    begin
                        rem_next = trial;
                        quo_next = quo_reg | (17'd1 << shamt);
                    end
                    step_next = step_reg - 5'd1;
                end
                else
                begin
                    if (axis_reg) ay_next = wght;
                    else ax_next = wght;
                    axis_next = 1'b1;
                    lo_next = '0;
                    hi_next = MW'(nr - NW'(2));
                    corner_next = 2'd0;
                    sum_next = '0;
                end
            end
            ST_COR_RD:  w_next = 34'(wxs) * 34'(wys);
            ST_COR_MUL: prod_next = mul_p;
            ST_COR_ACC:
            begin
                sum_next = sum_reg + 68'(prod_reg);
                corner_next = corner_reg + 2'd1;
            end
            ST_ROUND:
            begin
                if (rtop > 36'sd2147483647) res_next = 32'sh7fffffff;
                else if (rtop < -36'sd2147483648) res_next = 32'sh80000000;
                else res_next = rtop[31:0];
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ncol_reg  <= COUNT_W'(64);
            nrow_reg  <= COUNT_W'(64);
            axis_reg  <= 1'b0;
            end_reg   <= 1'b0;
            oor_reg   <= 1'b0;
            step_reg  <= '0;
            corner_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            end_reg   <= end_next;
            oor_reg   <= oor_next;
            step_reg  <= step_next;
            corner_reg <= corner_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_COLUMNS) ncol_reg <= cfg_data;
                else if (cfg_index == CFG_ROWS) nrow_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && op == OP_QUERY)
        begin
            qx_reg <= query_x;
            qy_reg <= query_y;
        end
        lo_reg <= lo_next;  hi_reg <= hi_next;  ci_reg <= ci_next;  rj_reg <= rj_next;
        blo_reg <= blo_next;  span_reg <= span_next;  rem_reg <= rem_next;
        quo_reg <= quo_next;  ax_reg <= ax_next;  ay_reg <= ay_next;
        w_reg <= w_next;  prod_reg <= prod_next;  sum_reg <= sum_next;
        res_reg <= res_next;
    end

    // outputs
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == ST_OUT);
    assign out_of_range = oor_reg;
    assign interpolated_value = oor_reg ? '0 : res_reg;

    // checks
    `BGI_ASSERT_IMPLY(a_busy_stall, clk, rst_n, out_valid, in_stall, "result while ready")
    `BGI_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(interpolated_value), "stalled result changed")
    `BGI_ASSERT_NEXT(a_query_start, clk, rst_n, in_acc && op == OP_QUERY,
        state_reg == ST_END_RD, "query did not start")
endmodule

// File: bench/testbench.sv
// self-checking testbench for the bilinear grid interpolation block
module testbench;
    import bgi_pkg::*;

    localparam int NCOL = MAX_COLUMNS_DEF;
    localparam int NROW = MAX_ROWS_DEF;
    localparam int DRAIN_CYCLES = 200;
    localparam int SIDE = 4;            // width of the two loaded grid strips

    typedef struct packed {
        op_t                     op;
        logic [INDEX_W-1:0]      col;
        logic [INDEX_W-1:0]      row;
        logic signed [DATA_W-1:0] lv;
        logic signed [DATA_W-1:0] qx;
        logic signed [DATA_W-1:0] qy;
    } request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     oor;
    } answer_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] op;
    logic [INDEX_W-1:0] column_index;
    logic [INDEX_W-1:0] row_index;
    logic signed [DATA_W-1:0] load_value;
    logic signed [DATA_W-1:0] query_x;
    logic signed [DATA_W-1:0] query_y;
    logic out_valid;
    logic out_stall;
    logic signed [DATA_W-1:0] interpolated_value;
    logic out_of_range;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [COUNT_W-1:0] cfg_data;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    int       errors;
    bit       gaps_on;
    bit       hold_sender;

    // predictor state
    int unsigned model_cols;
    int unsigned model_rows;
    logic signed [DATA_W-1:0] model_col_bp [NCOL];
    logic signed [DATA_W-1:0] model_row_bp [NROW];
    logic signed [DATA_W-1:0] model_grid [NCOL*NROW];

    // tables as planned by the stimulus, used to aim queries
    int plan_col_bp [NCOL];
    int plan_row_bp [NROW];
    int plan_cols;
    int plan_rows;

    bilinear_grid_interpolation u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .column_index(column_index), .row_index(row_index),
        .load_value(load_value), .query_x(query_x), .query_y(query_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .interpolated_value(interpolated_value), .out_of_range(out_of_range),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned clamp_count(int unsigned v, int unsigned maxv);
        if (v < 2)
            return 2;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // bisection for the largest cell whose lower breakpoint is <= q
    function automatic int unsigned find_cell(bit on_rows, longint q, int unsigned n);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        longint bp;
        lo = 0;
        hi = n - 2;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            bp = on_rows ? longint'(model_row_bp[mid]) : longint'(model_col_bp[mid]);
            if (bp <= q)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // unsigned q1.16 fraction of q between two breakpoints, 17 bits wide
    function automatic longint frac_weight(longint lower, longint upper, longint q);
        longint span;
        longint off;
        longint w;
        span = upper - lower;
        off = q - lower;
        if (span <= 0 || off <= 0)
            return 0;
        if (off >= span)
            return 65536;
        w = (off <<< 16) / span;
        return (w > 65536) ? 65536 : w;
    endfunction

    // expected result of one query against the predictor tables
    function automatic answer_t interpolate(longint x, longint y);
        answer_t r;
        int unsigned nc;
        int unsigned nr;
        int unsigned ci;
        int unsigned rj;
        longint wx [2];
        longint wy [2];
        longint sum;
        longint res;
        logic [63:0] u;
        nc = clamp_count(model_cols, NCOL);
        nr = clamp_count(model_rows, NROW);
        if (x < model_col_bp[0] || x > model_col_bp[nc-1] ||
            y < model_row_bp[0] || y > model_row_bp[nr-1])
        begin
            r.value = '0;
            r.oor = 1'b1;
            return r;
        end
        ci = find_cell(1'b0, x, nc);
        rj = find_cell(1'b1, y, nr);
        wx[1] = frac_weight(model_col_bp[ci], model_col_bp[ci+1], x);
        wy[1] = frac_weight(model_row_bp[rj], model_row_bp[rj+1], y);
        wx[0] = 65536 - wx[1];
        wy[0] = 65536 - wy[1];
        sum = 0;
        for (int a = 0; a < 2; a++)
            for (int b = 0; b < 2; b++)
                sum += wx[a] * wy[b] * longint'(model_grid[(ci+a)*NROW + rj + b]);
        u = 64'(sum) + 64'h8000_0000_0000_0000 + 64'h8000_0000;
        res = longint'(u >> 32) - 64'sh8000_0000;
        if (res > 64'sh7FFF_FFFF)
            res = 64'sh7FFF_FFFF;
        if (res < -64'sh8000_0000)
            res = -64'sh8000_0000;
        r.value = res[31:0];
        r.oor = 1'b0;
        return r;
    endfunction

    // apply one accepted request to the predictor
    function automatic void absorb_request(request_t rq);
        case (rq.op)
            OP_LOAD_COL:  model_col_bp[rq.col] = rq.lv;
            OP_LOAD_ROW:  model_row_bp[rq.row] = rq.lv;
            OP_LOAD_GRID: model_grid[rq.col*NROW + rq.row] = rq.lv;
            default:      expected_answers.push_back(interpolate(rq.qx, rq.qy));
        endcase
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op <= OP_LOAD_COL;
            column_index <= '0;
            row_index <= '0;
            load_value <= '0;
            query_x <= '0;
            query_y <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            request_t nx;
            if (in_valid)
                absorb_request(request_t'{op_t'(op), column_index, row_index,
                                          load_value, query_x, query_y});
            if (pending_requests.size() == 0 || hold_sender ||
                (gaps_on && $urandom_range(99) < 31))
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                nx = pending_requests.pop_front();
                in_valid <= 1'b1;
                op <= nx.op;
                column_index <= nx.col;
                row_index <= nx.row;
                load_value <= nx.lv;
                query_x <= nx.qx;
                query_y <= nx.qy;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                answer_t want;
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected result value=%0d oor=%0b",
                             $time, interpolated_value, out_of_range);
                    errors++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (interpolated_value !== want.value)
                    begin
                        $display("%0t: interpolated_value expected %0d actual %0d",
                                 $time, want.value, interpolated_value);
                        errors++;
                    end
                    if (out_of_range !== want.oor)
                    begin
                        $display("%0t: out_of_range expected %0b actual %0b",
                                 $time, want.oor, out_of_range);
                        errors++;
                    end
                end
            end
            out_stall <= gaps_on && ($urandom_range(99) < 31);
        end
    end

    task automatic push_load(op_t o, int c, int r, int v);
        pending_requests.push_back(request_t'{o, c[5:0], r[5:0], v, $urandom, $urandom});
    endtask

    task automatic push_query(int x, int y);
        pending_requests.push_back(request_t'{OP_QUERY, 6'($urandom), 6'($urandom),
                                              $urandom, x, y});
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_answers.size() != 0);
    endtask

    // register write while the block is idle, once every request has been taken and answered
    task automatic write_count(logic idx, int unsigned val);
        wait_idle();
        repeat (150) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[COUNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_COLUMNS)
            model_cols = val[COUNT_W-1:0];
        else
            model_rows = val[COUNT_W-1:0];
    endtask

    task automatic set_counts(int unsigned nc, int unsigned nr);
        write_count(CFG_COLUMNS, nc);
        write_count(CFG_ROWS, nr);
        plan_cols = clamp_count(nc, NCOL);
        plan_rows = clamp_count(nr, NROW);
    endtask

    // fill one breakpoint axis: ascending tight or wide, with repeats, or unordered
    task automatic load_axis(bit on_rows, int n, int mode);
        longint v;
        int t;
        int mn;
        int mx;
        int bp [NCOL];
        v = (mode == 1) ? -64'sh8000_0000 + $urandom_range(32'h3FFF_FFFF)
                        : -longint'($urandom_range(32'h3FFF_FFFF));
        for (int k = 0; k < n; k++)
        begin
            if (mode == 3)
                bp[k] = $urandom;
            else
            begin
                bp[k] = int'(v);
                if (mode == 2 && $urandom_range(2) == 0)
                    v += 0;
                else if (mode == 1)
                    v += $urandom_range(32'h01FF_FFFF);
                else
                    v += $urandom_range(32'h00FF_FFFF, 1);
            end
        end
        if (mode == 3)
        begin
            // smallest first and largest last so that queries still land inside
            mn = 0;
            mx = 0;
            for (int k = 1; k < n; k++)
            begin
                if (bp[k] < bp[mn])
                    mn = k;
                if (bp[k] > bp[mx])
                    mx = k;
            end
            t = bp[mn]; bp[mn] = bp[0]; bp[0] = t;
            if (mx == 0)
                mx = mn;
            t = bp[mx]; bp[mx] = bp[n-1]; bp[n-1] = t;
        end
        for (int k = 0; k < n; k++)
        begin
            if (on_rows)
            begin
                plan_row_bp[k] = bp[k];
                push_load(OP_LOAD_ROW, $urandom, k, bp[k]);
            end
            else
            begin
                plan_col_bp[k] = bp[k];
                push_load(OP_LOAD_COL, k, $urandom, bp[k]);
            end
        end
    endtask

    function automatic int grid_value();
        case ($urandom_range(5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    // coordinate aimed at an axis: mostly inside, sometimes on a breakpoint or outside
    function automatic int aim(bit on_rows);
        int n;
        longint lo;
        longint hi;
        n = on_rows ? plan_rows : plan_cols;
        lo = on_rows ? plan_row_bp[0] : plan_col_bp[0];
        hi = on_rows ? plan_row_bp[n-1] : plan_col_bp[n-1];
        case ($urandom_range(19))
            0:       return $urandom;
            1:       return int'(lo - 1 - $urandom_range(1000));
            2:       return int'(hi + 1 + $urandom_range(1000));
            3, 4:    return on_rows ? plan_row_bp[$urandom_range(n-1)]
                                    : plan_col_bp[$urandom_range(n-1)];
            default: return int'(lo + ((hi - lo + 1) * longint'($urandom >> 1) >>> 31));
        endcase
    endfunction

    task automatic random_phase(int unsigned nc, int unsigned nr, int reqs);
        int k;
        set_counts(nc, nr);
        load_axis(1'b0, plan_cols, $urandom_range(3));
        load_axis(1'b1, plan_rows, $urandom_range(3));
        for (int c = 0; c < plan_cols && c < 8; c++)
            for (int r = 0; r < plan_rows && r < 8; r++)
                push_load(OP_LOAD_GRID, c, r, grid_value());
        for (k = 0; k < reqs; k++)
        begin
            case ($urandom_range(19))
                0:       push_load(OP_LOAD_GRID, $urandom, $urandom, grid_value());
                1:       push_load(OP_LOAD_COL, $urandom, $urandom, $urandom);
                default: push_query(aim(1'b0), aim(1'b1));
            endcase
        end
    endtask

    // stimulus and end of run
    initial
    begin
        errors = 0;
        gaps_on = 1'b1;
        hold_sender = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_COLUMNS;
        cfg_data = '0;
        model_cols = NCOL;
        model_rows = NROW;
        for (int k = 0; k < NCOL; k++)
            model_col_bp[k] = '0;
        for (int k = 0; k < NROW; k++)
            model_row_bp[k] = '0;
        for (int k = 0; k < NCOL*NROW; k++)
            model_grid[k] = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // unit cell: corners, middle, just outside every edge of the span
        set_counts(2, 2);
        push_load(OP_LOAD_COL, 0, 0, 0);
        push_load(OP_LOAD_COL, 1, 0, 65536);
        push_load(OP_LOAD_ROW, 0, 0, 0);
        push_load(OP_LOAD_ROW, 0, 1, 65536);
        push_load(OP_LOAD_GRID, 0, 0, 32'sh7FFF_FFFF);
        push_load(OP_LOAD_GRID, 0, 1, 32'sh8000_0000);
        push_load(OP_LOAD_GRID, 1, 0, 0);
        push_load(OP_LOAD_GRID, 1, 1, -1);
        push_query(0, 0);
        push_query(65536, 65536);
        push_query(32768, 32768);
        push_query(-1, 0);
        push_query(65537, 0);
        push_query(0, -1);
        push_query(0, 65537);
        // full span breakpoints and saturated corners
        push_load(OP_LOAD_COL, 0, 0, 32'sh8000_0000);
        push_load(OP_LOAD_COL, 1, 0, 32'sh7FFF_FFFF);
        push_load(OP_LOAD_GRID, 1, 0, 32'sh7FFF_FFFF);
        push_query(32'sh8000_0000, 32768);
        push_query(32'sh7FFF_FFFF, 0);
        // degenerate cell
        push_load(OP_LOAD_COL, 0, 0, 5);
        push_load(OP_LOAD_COL, 1, 0, 5);
        push_query(5, 100);

        // full breakpoint tables and two grid strips; later one count stays within a strip
        set_counts(NCOL, SIDE);
        load_axis(1'b0, NCOL, 0);
        load_axis(1'b1, NROW, 0);
        for (int c = 0; c < NCOL; c++)
            for (int r = 0; r < NROW; r++)
                if (c < SIDE || r < SIDE)
                    push_load(OP_LOAD_GRID, c, r, grid_value());
        for (int k = 0; k < 60; k++)
            push_query(aim(1'b0), aim(1'b1));

        // counts below and above the legal range
        random_phase(0, 100, 60);
        random_phase(127, 1, 60);

        // a stretch with no idling, then a pause until all results are in
        gaps_on = 1'b0;
        random_phase(64, 2, 120);
        wait_idle();
        gaps_on = 1'b1;
        random_phase(2, 64, 120);
        while (pending_requests.size() > 60)
            @(posedge clk);
        hold_sender = 1'b1;
        while (expected_answers.size() != 0 || in_valid)
            @(posedge clk);
        hold_sender = 1'b0;

        for (int p = 0; p < 4; p++)
        begin
            if ($urandom_range(1) == 0)
                random_phase($urandom_range(127), $urandom_range(SIDE), 60);
            else
                random_phase($urandom_range(SIDE), $urandom_range(127), 60);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("** bilinear_grid_interpolation: PASSED **");
        else
            $display("** bilinear_grid_interpolation: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #(20 * 3000000);
        $display("** bilinear_grid_interpolation: FAILED **");
        $finish;
    end

endmodule
